[rtl/core/lmcr_pkg.sv]
// Shared types, constants and helpers of the LED matrix chain refresh core.
`timescale 1ns / 1ps
`default_nettype none
package lmcr_pkg;

  localparam int MAX_DISPLAYS                = 8;
  localparam int DEFAULT_REFRESH_PERIOD_LOG2 = 10;
  localparam int STORE_DEPTH                 = 64;
  localparam int IDX_W                       = 6;
  localparam int ROWS                        = 8;
  localparam int ROW_W                       = 3;
  localparam int DISP_W                      = 3;
  localparam int CNT_W                       = 4;
  localparam int BYTE_W                      = 8;
  localparam int WORD_W                      = 16;
  localparam int OP_W                        = 2;
  localparam int CFG_ADDR_W                  = 4;
  localparam int CFG_DATA_W                  = 32;

  localparam logic [1:0] REG_REFRESH_ENABLE  = 2'd0;
  localparam logic [1:0] REG_DISPLAY_COUNT   = 2'd1;
  localparam logic [1:0] REG_FLIP_HORIZONTAL = 2'd2;
  localparam logic [1:0] REG_FLIP_VERTICAL   = 2'd3;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_TICK  = 2'd1,
    OP_RAW   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_RAW
  } state_t;

  typedef struct packed {
    logic              refresh_enable;
    logic [CNT_W-1:0]  display_count;
    logic              flip_horizontal;
    logic              flip_vertical;
  } cfg_t;

  typedef struct packed {
    logic wr_en;
    logic tick;
    logic start;
    logic adv;
    logic raw_cap;
    logic raw_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic fire;
    logic out_free;
    logic last_pos;
  } dp_stat_t;

  function automatic logic [BYTE_W-1:0] reverse_byte(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    for (int i = 0; i < BYTE_W; i++) begin
      r[i] = v[BYTE_W-1-i];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/lmcr_if.sv]
// Request and result channel interfaces of the LED matrix chain refresh core.
`timescale 1ns / 1ps
`default_nettype none
interface lmcr_in_if;
  import lmcr_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [IDX_W-1:0]  byte_index;
  logic [BYTE_W-1:0] byte_value;
  logic [WORD_W-1:0] raw_word;
  logic              release_select;

  modport source (
    output valid, op, byte_index, byte_value, raw_word, release_select,
    input  ready
  );
  modport sink (
    input  valid, op, byte_index, byte_value, raw_word, release_select,
    output ready
  );
endinterface

interface lmcr_out_if;
  import lmcr_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word;
  logic              row_end;
  logic              last;

  modport source (
    output valid, word, row_end, last,
    input  ready
  );
  modport sink (
    input  valid, word, row_end, last,
    output ready
  );
endinterface
`default_nettype wire

[rtl/core/lmcr_ram.sv]
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lmcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/lmcr_datapath.sv]
// Datapath: frame store, tick counter, refresh position counters and result register.
`timescale 1ns / 1ps
`default_nettype none
module lmcr_datapath #(
  parameter int REFRESH_PERIOD_LOG2 = lmcr_pkg::DEFAULT_REFRESH_PERIOD_LOG2
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lmcr_pkg::cfg_t                cfg,
  input  wire lmcr_pkg::ctl_cmd_t            cmd,
  output lmcr_pkg::dp_stat_t                 stat,
  input  wire logic [lmcr_pkg::IDX_W-1:0]    byte_index,
  input  wire logic [lmcr_pkg::BYTE_W-1:0]   byte_value,
  input  wire logic [lmcr_pkg::WORD_W-1:0]   raw_word,
  input  wire logic                          release_select,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [lmcr_pkg::WORD_W-1:0]        out_word,
  output logic                               out_row_end,
  output logic                               out_last
);
  import lmcr_pkg::*;

  localparam int TICK_W = (REFRESH_PERIOD_LOG2 == 0) ? 1 : REFRESH_PERIOD_LOG2;
  localparam logic [CNT_W-1:0] MaxDisp = CNT_W'(MAX_DISPLAYS);
  localparam logic [ROW_W-1:0] LastRow = ROW_W'(ROWS - 1);

  logic [TICK_W-1:0]      tick_cnt_r, tick_cnt_nxt;
  logic [IDX_W-1:0]       pos_r, pos_nxt;
  logic [ROW_W-1:0]       row_r, row_nxt;
  logic [DISP_W-1:0]      disp_r, disp_nxt;
  logic [STORE_DEPTH-1:0] ent_vld_r, ent_vld_nxt;
  logic                   rd_vld_r;
  logic [WORD_W-1:0]      raw_hold_r;
  logic                   rel_hold_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]      out_word_r, out_word_nxt;
  logic                   out_row_end_r, out_row_end_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [CNT_W-1:0]  n_sat;
  logic [IDX_W-1:0]  total_m1;
  logic [IDX_W-1:0]  pos_sel;
  logic [IDX_W-1:0]  raddr;
  logic [BYTE_W-1:0] rdata;
  logic [BYTE_W-1:0] byte_sel;
  logic [BYTE_W-1:0] byte_out;
  logic [3:0]        row_addr;
  logic              disp_last;
  logic              mirror;

  assign n_sat     = (cfg.display_count > MaxDisp) ? MaxDisp : cfg.display_count;
  assign total_m1  = IDX_W'({n_sat, 3'b000} - 7'd1);
  assign disp_last = ({1'b0, disp_r} == (n_sat - 4'd1));
  assign mirror    = cfg.flip_horizontal ^ cfg.flip_vertical;

  assign pos_sel = cmd.start ? '0 : (cmd.adv ? (pos_r + 6'd1) : pos_r);
  assign raddr   = cfg.flip_horizontal ? (total_m1 - pos_sel) : pos_sel;

  lmcr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (byte_index),
    .wdata (byte_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign byte_sel = rd_vld_r ? rdata : '0;
  assign byte_out = cfg.flip_horizontal ? reverse_byte(byte_sel) : byte_sel;
  assign row_addr = mirror ? (4'd8 - {1'b0, row_r}) : ({1'b0, row_r} + 4'd1);

  always_comb begin
    tick_cnt_nxt = tick_cnt_r;
    if (cmd.tick) begin
      tick_cnt_nxt = (REFRESH_PERIOD_LOG2 == 0) ? '0 : tick_cnt_r + 1'b1;
    end
  end

  always_comb begin
    ent_vld_nxt = ent_vld_r;
    if (cmd.wr_en) begin
      ent_vld_nxt[byte_index] = 1'b1;
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    row_nxt  = row_r;
    disp_nxt = disp_r;
    if (cmd.start) begin
      pos_nxt  = '0;
      row_nxt  = '0;
      disp_nxt = '0;
    end else if (cmd.adv) begin
      pos_nxt = pos_r + 6'd1;
      if (disp_last) begin
        disp_nxt = '0;
        row_nxt  = row_r + 3'd1;
      end else begin
        disp_nxt = disp_r + 3'd1;
      end
    end
  end

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_word_nxt    = out_word_r;
    out_row_end_nxt = out_row_end_r;
    out_last_nxt    = out_last_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.adv) begin
      out_valid_nxt   = 1'b1;
      out_word_nxt    = {4'h0, row_addr, byte_out};
      out_row_end_nxt = disp_last;
      out_last_nxt    = disp_last && (row_r == LastRow);
    end else if (cmd.raw_load) begin
      out_valid_nxt   = 1'b1;
      out_word_nxt    = raw_hold_r;
      out_row_end_nxt = rel_hold_r;
      out_last_nxt    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_cnt_r  <= '0;
      ent_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      tick_cnt_r  <= tick_cnt_nxt;
      ent_vld_r   <= ent_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r         <= pos_nxt;
    row_r         <= row_nxt;
    disp_r        <= disp_nxt;
    rd_vld_r      <= ent_vld_r[raddr];
    out_word_r    <= out_word_nxt;
    out_row_end_r <= out_row_end_nxt;
    out_last_r    <= out_last_nxt;
    if (cmd.raw_cap) begin
      raw_hold_r <= raw_word;
      rel_hold_r <= release_select;
    end
  end

  assign stat.fire     = (tick_cnt_r == '0) && cfg.refresh_enable && (n_sat != '0);
  assign stat.out_free = !out_valid_r || out_ready;
  assign stat.last_pos = disp_last && (row_r == LastRow);

  assign out_valid   = out_valid_r;
  assign out_word    = out_word_r;
  assign out_row_end = out_row_end_r;
  assign out_last    = out_last_r;

endmodule
`default_nettype wire

[rtl/core/lmcr_ctrl.sv]
// Controller: request decode and refresh sequencing state machine.
`timescale 1ns / 1ps
`default_nettype none
module lmcr_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [lmcr_pkg::OP_W-1:0]   op,
  input  wire lmcr_pkg::dp_stat_t          stat,
  output lmcr_pkg::ctl_cmd_t               cmd
);
  import lmcr_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (op)
            OP_TICK: begin
              if (stat.fire) begin
                state_nxt = ST_RUN;
              end
            end
            OP_RAW:  state_nxt = ST_RAW;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RUN: begin
        if (stat.out_free && stat.last_pos) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RAW: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (op)
            OP_WRITE: cmd.wr_en = 1'b1;
            OP_TICK: begin
              cmd.tick  = 1'b1;
              cmd.start = stat.fire;
            end
            OP_RAW:  cmd.raw_cap = 1'b1;
            default: cmd = '0;
          endcase
        end
      end
      ST_RUN:  cmd.adv      = stat.out_free;
      ST_RAW:  cmd.raw_load = stat.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/core/led_matrix_chain_refresh_core.sv]
// Top level of the LED matrix chain refresh core: configuration port and wiring.
`timescale 1ns / 1ps
`default_nettype none
// Keeps 8 row bytes per display for a chain of up to eight 8x8 LED matrix
// displays and turns requests into 16-bit words (row address in bits 11:8, row
// byte in bits 7:0) for a serial pin stage. A write request is stored as it is taken; a
// raw-word request is captured and then loaded into the result register as one
// word. A tick request that fires a refresh yields 8*n words (n = displays,
// saturated at eight) at one word per cycle while the result side keeps up,
// once the first byte has been fetched; the single read port of the 64-byte frame
// store sets that pace. No request is taken while words of a refresh or a raw
// word are still being produced. The frame store reads as zero after reset
// until written, with no clearing pass. Registers are written over the APB
// port at byte addresses 0, 4, 8 and 12: enable, display count, horizontal
// flip, vertical flip.
module led_matrix_chain_refresh_core #(
  parameter int REFRESH_PERIOD_LOG2 = lmcr_pkg::DEFAULT_REFRESH_PERIOD_LOG2
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  lmcr_in_if.sink                                in_req,
  lmcr_out_if.source                             out_rsp,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [lmcr_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [lmcr_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [lmcr_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                   pready
);
  import lmcr_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;
  logic     in_ready;
  logic     out_valid;
  logic     out_row_end;
  logic     out_last;
  logic [WORD_W-1:0] out_word;

  assign pready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_REFRESH_ENABLE:  cfg_nxt.refresh_enable  = pwdata[0];
        REG_DISPLAY_COUNT:   cfg_nxt.display_count   = pwdata[CNT_W-1:0];
        REG_FLIP_HORIZONTAL: cfg_nxt.flip_horizontal = pwdata[0];
        REG_FLIP_VERTICAL:   cfg_nxt.flip_vertical   = pwdata[0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_REFRESH_ENABLE:  prdata[0]         = cfg_r.refresh_enable;
      REG_DISPLAY_COUNT:   prdata[CNT_W-1:0] = cfg_r.display_count;
      REG_FLIP_HORIZONTAL: prdata[0]         = cfg_r.flip_horizontal;
      REG_FLIP_VERTICAL:   prdata[0]         = cfg_r.flip_vertical;
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.refresh_enable  <= 1'b0;
      cfg_r.display_count   <= CNT_W'(1);
      cfg_r.flip_horizontal <= 1'b0;
      cfg_r.flip_vertical   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lmcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .op       (in_req.op),
    .stat     (dp_stat),
    .cmd      (ctl_cmd)
  );

  lmcr_datapath #(
    .REFRESH_PERIOD_LOG2 (REFRESH_PERIOD_LOG2)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .cmd            (ctl_cmd),
    .stat           (dp_stat),
    .byte_index     (in_req.byte_index),
    .byte_value     (in_req.byte_value),
    .raw_word       (in_req.raw_word),
    .release_select (in_req.release_select),
    .out_valid      (out_valid),
    .out_ready      (out_rsp.ready),
    .out_word       (out_word),
    .out_row_end    (out_row_end),
    .out_last       (out_last)
  );

  assign in_req.ready    = in_ready;
  assign out_rsp.valid   = out_valid;
  assign out_rsp.word    = out_word;
  assign out_rsp.row_end = out_row_end;
  assign out_rsp.last    = out_last;

  a_no_request_during_refresh: assert property (
    @(posedge clk) disable iff (!rst_n)
    ctl_cmd.adv |-> !in_ready
  ) else $error("request taken while refresh words are produced");

  a_raw_blocks_next: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_ready && (in_req.op == OP_RAW)) |=> !in_ready
  ) else $error("raw word request not held before its result");

  a_start_only_on_tick: assert property (
    @(posedge clk) disable iff (!rst_n)
    ctl_cmd.start |-> (ctl_cmd.tick && cfg_r.refresh_enable)
  ) else $error("refresh started without an enabled tick");

  a_single_load: assert property (
    @(posedge clk) disable iff (!rst_n)
    !(ctl_cmd.adv && ctl_cmd.raw_load)
  ) else $error("result register loaded from two sources");

endmodule
`default_nettype wire
